// ===== sv/rle_scanline_expander_unit_macros.svh =====
// Assertion macros for the run-length scanline expander.
// Used by the top level; expects clk_i and rst_ni in scope.
`ifndef RLE_SCANLINE_EXPANDER_UNIT_MACROS_SVH
`define RLE_SCANLINE_EXPANDER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsx_pkg.sv =====
// Shared types and constants for the run-length scanline expander.
// No dependencies; imported by every module of the block.
package rsx_pkg;

  localparam int unsigned ElemW   = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned QDepth  = 2;

  localparam logic [6:0] CountMask = 7'h7f;
  localparam int unsigned CopyFlagBit = 7;

  // Decoder phase.
  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COPY   = 2'd1,
    PH_REPEAT = 2'd2,
    PH_DONE   = 2'd3
  } rsx_phase_e;

  // Result kind on the line_status field.
  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_OK  = 2'd1,
    ST_ERR = 2'd2
  } rsx_status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_WIDE_SAMPLES = 1'b1
  } rsx_reg_e;

  // Everything one input element produces: an optional run, then an optional status.
  typedef struct packed {
    logic [ElemW-1:0]  value;
    logic [CountW-1:0] run_len;
    logic              has_run;
    logic              has_status;
    logic              status_ok;
  } rsx_entry_t;

endpackage

// ===== sv/rsx_out_queue.sv =====
// Result queue: holds decoded entries and unrolls each into one or two results.
// Depends on rsx_pkg.
module rsx_out_queue import rsx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  rsx_entry_t        entry_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ElemW-1:0]  sample_value_o,
  output logic [CountW-1:0] run_length_o,
  output logic [1:0]        line_status_o,
  output logic              last_of_run_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  rsx_entry_t          mem_q [QDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                half_q, half_d;
  rsx_entry_t          head;
  logic                show_status;
  logic                xfer;
  logic                pop;

  assign head        = mem_q[rd_ptr_q];
  assign out_valid_o = (count_q != '0);
  assign full_o      = (count_q == CntW'(QDepth));
  // Status follows the run of the same entry, if there is one.
  assign show_status = half_q || !head.has_run;
  assign xfer        = out_valid_o && out_ready_i;
  assign pop         = xfer && (show_status || !head.has_status);

  always_comb begin
    if (show_status) begin
      sample_value_o = '0;
      run_length_o   = '0;
      line_status_o  = head.status_ok ? ST_OK : ST_ERR;
      last_of_run_o  = 1'b1;
    end else begin
      sample_value_o = head.value;
      run_length_o   = head.run_len;
      line_status_o  = ST_RUN;
      last_of_run_o  = !head.has_status;
    end
  end

  always_comb begin
    wr_ptr_d = push_i ? PtrW'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop ? PtrW'(rd_ptr_q + 1'b1) : rd_ptr_q;
    count_d  = CntW'(count_q + CntW'(push_i) - CntW'(pop));
    if (pop) begin
      half_d = 1'b0;
    end else if (xfer) begin
      half_d = 1'b1;
    end else begin
      half_d = half_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      half_q   <= 1'b0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      half_q   <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

// ===== sv/rsx_decode.sv =====
// Scanline decode state machine: header, copy and repeat handling per element.
// Depends on rsx_pkg.
module rsx_decode import rsx_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  logic [ElemW-1:0] elem_i,
  input  logic             last_i,
  input  logic [ElemW-1:0] line_width_i,
  input  logic             wide_i,
  output logic             push_o,
  output rsx_entry_t       entry_o
);

  localparam logic [ElemW-1:0] SampleMask = {ElemW{1'b1}} >> (ElemW - SAMPLE_BITS);

  rsx_phase_e        phase_q, phase_d, ph;
  logic [CountW-1:0] pend_q, pend_d;
  logic [ElemW-1:0]  done_q, done_d;
  logic              err_q, err_d;

  logic [ElemW-1:0]  elem;
  logic [CountW-1:0] count;
  logic [ElemW:0]    copy_end;
  logic [ElemW-1:0]  left;
  logic              has_run;

  always_comb begin
    elem    = wide_i ? elem_i : {8'h00, elem_i[7:0]};
    count   = elem[CountW-1:0] & CountMask;
    copy_end = {1'b0, done_q} + {{(ElemW - CountW + 1){1'b0}}, count};
    left    = line_width_i - done_q;

    // A full line (also after a width change) finishes decoding.
    ph = ((phase_q != PH_DONE) && (done_q >= line_width_i)) ? PH_DONE : phase_q;

    phase_d = ph;
    pend_d  = pend_q;
    done_d  = done_q;
    err_d   = err_q;
    has_run = 1'b0;
    entry_o.value   = wide_i ? (elem & SampleMask) : elem;
    entry_o.run_len = 7'd1;

    case (ph)
      PH_HEADER: begin
        if (count == '0) begin
          phase_d = PH_DONE;
        end else if (elem[CopyFlagBit]) begin
          if (copy_end > {1'b0, line_width_i}) begin
            err_d   = 1'b1;
            phase_d = PH_DONE;
            pend_d  = '0;
          end else begin
            pend_d  = count;
            phase_d = PH_COPY;
          end
        end else begin
          pend_d  = count;
          phase_d = PH_REPEAT;
        end
      end
      PH_COPY: begin
        has_run = 1'b1;
        done_d  = done_q + 1'b1;
        pend_d  = pend_q - 1'b1;
        if (done_d >= line_width_i) begin
          phase_d = PH_DONE;
        end else if (pend_d == '0) begin
          phase_d = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        if (({{(ElemW - CountW){1'b0}}, pend_q} > left) && !wide_i) begin
          // Byte mode: overflowing repeat is an error, no run.
          err_d   = 1'b1;
          phase_d = PH_DONE;
          pend_d  = '0;
        end else begin
          has_run = 1'b1;
          // Word mode: clip the run to what is left of the line.
          if ({{(ElemW - CountW){1'b0}}, pend_q} > left) begin
            entry_o.run_len = left[CountW-1:0];
          end else begin
            entry_o.run_len = pend_q;
          end
          done_d = done_q + {{(ElemW - CountW){1'b0}}, entry_o.run_len};
          pend_d = '0;
          phase_d = (done_d >= line_width_i) ? PH_DONE : PH_HEADER;
        end
      end
      default: begin
      end
    endcase

    // Line end: owed elements count as an error; report, then clear.
    entry_o.has_run    = has_run;
    entry_o.has_status = last_i;
    entry_o.status_ok  = 1'b0;
    if (last_i) begin
      if ((phase_d == PH_COPY) || (phase_d == PH_REPEAT)) begin
        err_d = 1'b1;
      end
      entry_o.status_ok = !err_d && (done_d == line_width_i);
      phase_d = PH_HEADER;
      pend_d  = '0;
      done_d  = '0;
      err_d   = 1'b0;
    end

    push_o = fire_i && (has_run || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      pend_q  <= '0;
      done_q  <= '0;
      err_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      err_q   <= err_d;
    end
  end

endmodule

// ===== sv/rle_scanline_expander_unit.sv =====
// Run-length scanline expander, top level.
// An accepted element passes the input register and then the result queue before its first result shows.
// Throughput: one element per cycle while the result queue has a free slot; an
// element that yields a run plus a status gives a run result, then a status result.
// Reset: asynchronous, active low; clears decode state, the result queue,
// and sets line_width to 1 and wide_samples to 0.
`include "rle_scanline_expander_unit_macros.svh"
module rle_scanline_expander_unit import rsx_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration write port
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [ElemW-1:0]  cfg_wdata_i,
  // compressed element channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ElemW-1:0]  code_element_i,
  input  logic              line_end_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ElemW-1:0]  sample_value_o,
  output logic [CountW-1:0] run_length_o,
  output logic [1:0]        line_status_o,
  output logic              last_of_run_o
);

  // Configuration registers; the user must write them only while the block is idle (not enforced here).
  logic [ElemW-1:0] line_width_q;
  logic             wide_q;

  // Input register: holds one element until the decoder can take it.
  logic             in_valid_q, in_valid_d;
  logic [ElemW-1:0] elem_q;
  logic             last_q;

  logic             in_xfer;
  logic             fire;
  logic             q_full;
  logic             push;
  rsx_entry_t       entry;

  // Advance the held element whenever the queue has a free slot; the
  // decision does not depend on the output side in the same cycle.
  assign fire       = in_valid_q && !q_full;
  assign in_ready_o = !in_valid_q || fire;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      line_width_q <= 16'd1;
      wide_q       <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_we_i) begin
        case (rsx_reg_e'(cfg_index_i))
          REG_LINE_WIDTH:   line_width_q <= cfg_wdata_i;
          REG_WIDE_SAMPLES: wide_q       <= cfg_wdata_i[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload of the input register; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      elem_q <= code_element_i;
      last_q <= line_end_i;
    end
  end

  // Decode one element per fire against the line state.
  rsx_decode #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .elem_i       (elem_q),
    .last_i       (last_q),
    .line_width_i (line_width_q),
    .wide_i       (wide_q),
    .push_o       (push),
    .entry_o      (entry)
  );

  // Queue the decoded entries and present their results one transfer at a time.
  rsx_out_queue u_out_queue (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .entry_i        (entry),
    .full_o         (q_full),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_value_o (sample_value_o),
    .run_length_o   (run_length_o),
    .line_status_o  (line_status_o),
    .last_of_run_o  (last_of_run_o)
  );

  // A status result always closes the results of its element.
  `RSX_ASSERT_NOW(a_status_last, out_valid_o && (line_status_o != ST_RUN), last_of_run_o && (run_length_o == '0) && (sample_value_o == '0), "status result must be last and empty")
  // A run always carries a nonzero length.
  `RSX_ASSERT_NOW(a_run_nonzero, out_valid_o && (line_status_o == ST_RUN), run_length_o != '0, "run result with zero length")
  // A held element that did not advance stays in the input register.
  `RSX_ASSERT_NEXT(a_hold_input, in_valid_q && !fire, in_valid_q && $stable(elem_q) && $stable(last_q), "held element lost or changed")
  // Nothing is pushed into a full queue.
  `RSX_ASSERT_NOW(a_no_overflow, q_full, !push, "push into full result queue")

endmodule
